>>> rtl/upq_pkg.sv
// ----------------------------------------------------------------------------
// upq_pkg
// Shared types, constants and helpers of the unsorted-table priority queue.
// ----------------------------------------------------------------------------
package upq_pkg;

  // Table geometry
  localparam int unsigned Depth    = 16;
  localparam int unsigned KeyBits  = 16;
  localparam int unsigned PrioBits = 14;
  localparam int unsigned IdxW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW     = $clog2(Depth + 1);

  // Action codes
  localparam logic [2:0] ActEnq   = 3'd0;
  localparam logic [2:0] ActDeq   = 3'd1;
  localparam logic [2:0] ActChg   = 3'd2;
  localparam logic [2:0] ActPeek  = 3'd3;
  localparam logic [2:0] ActClear = 3'd4;

  // Status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StEmpty    = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StRaise    = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] key;
    logic [13:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [15:0] out_key;
    logic [13:0] out_priority;
    logic [4:0]  entry_count;
    logic [2:0]  status;
  } rsp_t;

  // One table entry as it sits in the RAM
  typedef struct packed {
    logic [KeyBits-1:0]  key;
    logic [PrioBits-1:0] prio;
  } entry_t;

  // Scan unit control
  typedef struct packed {
    logic clear;
    logic valid;
  } scan_ctl_t;

  // Scan unit results
  typedef struct packed {
    logic [IdxW-1:0]     best_slot;
    entry_t              best;
    logic                found;
    logic [IdxW-1:0]     match_slot;
    logic [PrioBits-1:0] match_prio;
    entry_t              last;
  } scan_res_t;

  function automatic rsp_t make_rsp(input logic [15:0] key, input logic [13:0] prio,
                                    input logic [CntW-1:0] cnt, input logic [2:0] status);
    rsp_t r;
    r.out_key      = key;
    r.out_priority = prio;
    r.entry_count  = 5'(cnt);
    r.status       = status;
    return r;
  endfunction

endpackage

>>> rtl/upq_ram.sv
// ----------------------------------------------------------------------------
// upq_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module upq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/upq_scan.sv
// ----------------------------------------------------------------------------
// upq_scan
// Walks the read-back entries: tracks the first minimum, the first key match
// and the last entry of the table.
// ----------------------------------------------------------------------------
module upq_scan (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  upq_pkg::scan_ctl_t              ctl_i,
  input  logic [upq_pkg::IdxW-1:0]        idx_i,
  input  logic [upq_pkg::IdxW-1:0]        last_idx_i,
  input  upq_pkg::entry_t                 data_i,
  input  logic [upq_pkg::KeyBits-1:0]     key_i,
  output upq_pkg::scan_res_t              res_o
);

  logic                             have_q, found_q;
  logic [upq_pkg::IdxW-1:0]         best_slot_q, match_slot_q;
  upq_pkg::entry_t                  best_q, last_q;
  logic [upq_pkg::PrioBits-1:0]     match_prio_q;
  logic                             take_best, take_match;

  // Strictly lower wins, so ties stay with the lowest slot
  assign take_best  = ctl_i.valid && (!have_q || (data_i.prio < best_q.prio));
  assign take_match = ctl_i.valid && !found_q && (data_i.key == key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q  <= 1'b0;
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      have_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (take_best)  have_q  <= 1'b1;
      if (take_match) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_q      <= data_i;
      best_slot_q <= idx_i;
    end
    if (take_match) begin
      match_slot_q <= idx_i;
      match_prio_q <= data_i.prio;
    end
    if (ctl_i.valid && (idx_i == last_idx_i)) begin
      last_q <= data_i;
    end
  end

  always_comb begin
    res_o.best_slot  = best_slot_q;
    res_o.best       = best_q;
    res_o.found      = found_q;
    res_o.match_slot = match_slot_q;
    res_o.match_prio = match_prio_q;
    res_o.last       = last_q;
  end

endmodule

>>> rtl/unsorted_array_priority_queue_core.sv
// ----------------------------------------------------------------------------
// unsorted_array_priority_queue_core
// Min priority queue kept as an unsorted table in one RAM.
// ----------------------------------------------------------------------------
// Timing: enqueue, clear, unused codes and empty/not-found answers give their
//   result strobe in the cycle after the transaction; dequeue, peek and change
//   priority give it after the S_SCAN, S_WAIT and S_FIN states, registered.
// Throughput: busy during a scan, new transactions taken only when idle; the
//   RAM read port scan, one entry per cycle, sets the scanning operations.
// Reset: entry count and control clear at once; table contents stay undefined.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module unsorted_array_priority_queue_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  upq_pkg::req_t req_i,
  output logic          result_valid_o,
  output upq_pkg::rsp_t rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WAIT = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [2:0]                   action;
    logic [upq_pkg::KeyBits-1:0]  key;
    logic [upq_pkg::PrioBits-1:0] prio;
  } op_t;

  state_e                    state_q, state_d;
  logic [upq_pkg::CntW-1:0]  count_q, count_d;
  logic [upq_pkg::IdxW-1:0]  idx_q, idx_d;
  op_t                       op_q, op_d;
  logic                      rd_vld_q;
  logic [upq_pkg::IdxW-1:0]  rd_idx_q;
  upq_pkg::rsp_t             rsp_q, rsp_d;
  logic                      rsp_vld_q, rsp_vld_d;

  // RAM ports
  logic                      we, re;
  logic [upq_pkg::IdxW-1:0]  waddr, raddr, last_idx;
  upq_pkg::entry_t           wdata, rdata;

  upq_pkg::scan_ctl_t        scan_ctl;
  upq_pkg::scan_res_t        scan_res;

  assign busy     = (state_q != S_IDLE);
  assign last_idx = upq_pkg::IdxW'(count_q - 1'b1);

  upq_ram #(
    .Width ($bits(upq_pkg::entry_t)),
    .Depth (upq_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  upq_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .idx_i      (rd_idx_q),
    .last_idx_i (last_idx),
    .data_i     (rdata),
    .key_i      (op_q.key),
    .res_o      (scan_res)
  );

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    idx_d          = idx_q;
    op_d           = op_q;
    rsp_d          = rsp_q;
    rsp_vld_d      = 1'b0;
    we             = 1'b0;
    waddr          = idx_q;
    wdata          = '0;
    re             = 1'b0;
    raddr          = idx_q;
    scan_ctl.clear = 1'b0;
    // Read data for the address issued last cycle is valid while rd_vld_q is set
    scan_ctl.valid = rd_vld_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          // Capture the transaction; keys keep only the table's key width
          op_d.action = req_i.action;
          op_d.key    = upq_pkg::KeyBits'(req_i.key);
          op_d.prio   = req_i.priority_req;
          rsp_vld_d   = 1'b1;
          unique case (req_i.action)
            upq_pkg::ActEnq: begin
              if (count_q >= upq_pkg::CntW'(upq_pkg::Depth)) begin
                rsp_d = upq_pkg::make_rsp('0, '0, count_q, upq_pkg::StFull);
              end else begin
                // Append at the tail slot
                we         = 1'b1;
                waddr      = upq_pkg::IdxW'(count_q);
                wdata.key  = upq_pkg::KeyBits'(req_i.key);
                wdata.prio = req_i.priority_req;
                count_d    = count_q + 1'b1;
                rsp_d      = upq_pkg::make_rsp('0, '0, count_d, upq_pkg::StOk);
              end
            end
            upq_pkg::ActDeq, upq_pkg::ActPeek: begin
              if (count_q == '0) begin
                rsp_d = upq_pkg::make_rsp('0, '0, count_q, upq_pkg::StEmpty);
              end else begin
                // Start the scan; the result waits for its end
                rsp_vld_d      = 1'b0;
                scan_ctl.clear = 1'b1;
                idx_d          = '0;
                state_d        = S_SCAN;
              end
            end
            upq_pkg::ActChg: begin
              if (count_q == '0) begin
                rsp_d = upq_pkg::make_rsp('0, '0, count_q, upq_pkg::StNotFound);
              end else begin
                rsp_vld_d      = 1'b0;
                scan_ctl.clear = 1'b1;
                idx_d          = '0;
                state_d        = S_SCAN;
              end
            end
            upq_pkg::ActClear: begin
              count_d = '0;
              rsp_d   = upq_pkg::make_rsp('0, '0, count_d, upq_pkg::StOk);
            end
            default: begin
              // Unused codes: answer ok, touch nothing
              rsp_d = upq_pkg::make_rsp('0, '0, count_q, upq_pkg::StOk);
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read per cycle, slot 0 up to the tail
        re    = 1'b1;
        raddr = idx_q;
        idx_d = upq_pkg::IdxW'(idx_q + 1'b1);
        if (idx_q == last_idx) begin
          state_d = S_WAIT;
        end
      end

      S_WAIT: begin
        // Last read data lands in the scan unit at the end of this cycle
        state_d = S_FIN;
      end

      S_FIN: begin
        state_d   = S_IDLE;
        rsp_vld_d = 1'b1;
        unique case (op_q.action)
          upq_pkg::ActDeq: begin
            // Move the tail entry into the freed slot, shrink the table
            we      = 1'b1;
            waddr   = scan_res.best_slot;
            wdata   = scan_res.last;
            count_d = count_q - 1'b1;
            rsp_d   = upq_pkg::make_rsp(16'(scan_res.best.key), scan_res.best.prio,
                                        count_d, upq_pkg::StOk);
          end
          upq_pkg::ActPeek: begin
            rsp_d = upq_pkg::make_rsp(16'(scan_res.best.key), scan_res.best.prio,
                                      count_q, upq_pkg::StOk);
          end
          upq_pkg::ActChg: begin
            if (!scan_res.found) begin
              rsp_d = upq_pkg::make_rsp('0, '0, count_q, upq_pkg::StNotFound);
            end else if (scan_res.match_prio < op_q.prio) begin
              rsp_d = upq_pkg::make_rsp('0, '0, count_q, upq_pkg::StRaise);
            end else begin
              we         = 1'b1;
              waddr      = scan_res.match_slot;
              wdata.key  = op_q.key;
              wdata.prio = op_q.prio;
              rsp_d      = upq_pkg::make_rsp('0, '0, count_q, upq_pkg::StOk);
            end
          end
          default: begin
            rsp_d = upq_pkg::make_rsp('0, '0, count_q, upq_pkg::StOk);
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      rd_vld_q  <= re;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    rsp_q    <= rsp_d;
    rd_idx_q <= raddr;
  end

  assign result_valid_o = rsp_vld_q;
  assign rsp_o          = rsp_q;

endmodule

>>> rtl/upq_chk.sv
// ----------------------------------------------------------------------------
// upq_chk
// Port-level checks of the priority queue core, bound to the top level.
// ----------------------------------------------------------------------------
module upq_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input upq_pkg::req_t req_i,
  input logic          result_valid_o,
  input upq_pkg::rsp_t rsp_o
);

  // An accepted transaction is either answered next cycle or keeps the core busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (result_valid_o || busy))
    else $error("accepted transaction neither answered nor in progress");

  // A result follows an accept or the end of a scan, never appears on its own
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start && !busy) || $fell(busy)))
    else $error("result strobe without a transaction");

  // Error results (any status other than ok) carry no entry
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status != upq_pkg::StOk)) |->
      ((rsp_o.out_key == '0) && (rsp_o.out_priority == '0)))
    else $error("non-ok result carries an entry");

  // Full and empty answers agree with the entry count
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status == upq_pkg::StFull)) |->
      (rsp_o.entry_count == 5'(upq_pkg::Depth)))
    else $error("full status with table not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (rsp_o.status == upq_pkg::StEmpty)) |->
      (rsp_o.entry_count == '0))
    else $error("empty status with entries held");

endmodule

bind unsorted_array_priority_queue_core upq_chk u_upq_chk (.*);
